// ----- design/rcs_pkg.sv -----
package rcs_pkg;

  // Fixed field widths.
  localparam int PHASE_BITS  = 3;
  localparam int TICK_BITS   = 16;
  localparam int REPEAT_BITS = 16;
  localparam int INDEX_BITS  = 3;

  // Default build values.
  localparam int DEF_MAX_PHASES = 6;
  localparam int DEF_TIME_BITS  = 16;

  // Reset value of the phase count register.
  localparam logic [PHASE_BITS-1:0] PHASE_COUNT_RESET = 3'd2;

  // Register indexes.
  localparam logic [INDEX_BITS-1:0] REG_PHASE_COUNT = 3'd0;
  localparam logic [INDEX_BITS-1:0] REG_PHASE0      = 3'd1;

  // Operation codes.
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2
  } op_e;

  typedef struct packed {
    logic [1:0]             op;
    logic [REPEAT_BITS-1:0] repeats;
    logic                   allow;
  } in_t;

  typedef struct packed {
    logic motor_on;
    logic ringing;
    logic started;
    logic blocked;
    logic finished;
  } out_t;

endpackage

// ----- design/ring_cadence_sequencer_unit.sv -----
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall  in_data (in_t: op, repeats, allow)
// out       output     out_valid/ out_stall out_data (out_t: motor_on .. finished)
// cfg       input      cfg_valid/ cfg_ready cfg_index, cfg_data
//
// Every transaction on in yields one transaction on out via the input and
// result registers. One item per cycle is sustained while out is not
// stalled; the phase counter compare and increment between the registers
// set that figure. Reset is synchronous and clears the sequencer state and
// all valid flags. A stall on out holds the result register and, once the
// input register is also full, stalls in in the same cycle.
module ring_cadence_sequencer_unit
  import rcs_pkg::*;
#(
  parameter int MAX_PHASES = DEF_MAX_PHASES,
  parameter int TIME_BITS  = DEF_TIME_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_t                  out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [INDEX_BITS-1:0] cfg_index,
  input  logic [TICK_BITS-1:0]  cfg_data
);

  logic                                 s1_valid;
  in_t                                  s1_data;
  logic                                 advance;
  out_t                                 core_result;
  logic [PHASE_BITS-1:0]                phase_count;
  logic [MAX_PHASES-1:0][TICK_BITS-1:0] phase_ticks;

  rcs_cfg #(
    .MAX_PHASES(MAX_PHASES)
  ) u_cfg (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .phase_count(phase_count),
    .phase_ticks(phase_ticks)
  );

  rcs_core #(
    .MAX_PHASES(MAX_PHASES),
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .update     (advance),
    .item       (s1_data),
    .phase_count(phase_count),
    .phase_ticks(phase_ticks),
    .result     (core_result)
  );

  // The input register moves on unless the result register is held.
  assign advance  = s1_valid && !(out_valid && out_stall);
  assign in_stall = s1_valid && out_valid && out_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data <= in_data;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= core_result;
    end
  end

endmodule

// ----- design/rcs_cfg.sv -----
module rcs_cfg
  import rcs_pkg::*;
#(
  parameter int MAX_PHASES = DEF_MAX_PHASES
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [INDEX_BITS-1:0]                cfg_index,
  input  logic [TICK_BITS-1:0]                 cfg_data,
  output logic [PHASE_BITS-1:0]                phase_count,
  output logic [MAX_PHASES-1:0][TICK_BITS-1:0] phase_ticks
);

  // Writes are taken at any time.
  assign cfg_ready = 1'b1;

  // Register file; indexes with no register are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_count <= PHASE_COUNT_RESET;
      phase_ticks <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == REG_PHASE_COUNT) begin
        phase_count <= cfg_data[PHASE_BITS-1:0];
      end
      for (int i = 0; i < MAX_PHASES; i++) begin
        if (cfg_index == INDEX_BITS'(int'(REG_PHASE0) + i)) begin
          phase_ticks[i] <= cfg_data;
        end
      end
    end
  end

endmodule

// ----- design/rcs_core.sv -----
module rcs_core
  import rcs_pkg::*;
#(
  parameter int MAX_PHASES = DEF_MAX_PHASES,
  parameter int TIME_BITS  = DEF_TIME_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 update,
  input  in_t                                  item,
  input  logic [PHASE_BITS-1:0]                phase_count,
  input  logic [MAX_PHASES-1:0][TICK_BITS-1:0] phase_ticks,
  output out_t                                 result
);

  localparam int CMP_W = (TIME_BITS > TICK_BITS) ? TIME_BITS : TICK_BITS;
  localparam logic [TIME_BITS-1:0]  TIME_MAX = {TIME_BITS{1'b1}};
  localparam logic [PHASE_BITS-1:0] MAX_PH   = PHASE_BITS'(MAX_PHASES);

  logic                   active, active_next;
  logic [PHASE_BITS-1:0]  phase_index, phase_index_next;
  logic [TIME_BITS-1:0]   elapsed, elapsed_next;
  logic [REPEAT_BITS-1:0] repeats_left, repeats_left_next;
  logic                   drive, drive_next;

  logic [PHASE_BITS-1:0]  eff_count;
  logic [PHASE_BITS-1:0]  idx, idx_inc;
  logic [TIME_BITS-1:0]   elapsed_inc;
  logic [TICK_BITS-1:0]   cur_ticks;
  logic                   started, blocked, finished;

  // Phase count clamped to the supported range.
  always_comb begin
    if (phase_count == '0) begin
      eff_count = PHASE_BITS'(1);
    end else if (phase_count > MAX_PH) begin
      eff_count = MAX_PH;
    end else begin
      eff_count = phase_count;
    end
  end

  // Current phase, its duration and the saturated elapsed count.
  always_comb begin
    idx = (phase_index < MAX_PH) ? phase_index : '0;
    cur_ticks = '0;
    for (int i = 0; i < MAX_PHASES; i++) begin
      if (idx == PHASE_BITS'(i)) begin
        cur_ticks = phase_ticks[i];
      end
    end
    idx_inc = idx + PHASE_BITS'(1);
    elapsed_inc = (elapsed == TIME_MAX) ? elapsed : elapsed + TIME_BITS'(1);
  end

  // Next state for the item in hand.
  always_comb begin
    active_next       = active;
    phase_index_next  = phase_index;
    elapsed_next      = elapsed;
    repeats_left_next = repeats_left;
    drive_next        = drive;
    started           = 1'b0;
    blocked           = 1'b0;
    finished          = 1'b0;
    unique case (item.op)
      OP_TICK: begin
        if (active) begin
          if (CMP_W'(elapsed_inc) >= CMP_W'(cur_ticks)) begin
            if (idx_inc >= eff_count) begin
              // Wrap to the first phase; the last repeat ends the ring.
              if (repeats_left == REPEAT_BITS'(1)) begin
                repeats_left_next = '0;
                active_next       = 1'b0;
                drive_next        = 1'b0;
                phase_index_next  = '0;
                elapsed_next      = '0;
                finished          = 1'b1;
              end else begin
                if (repeats_left != '0) begin
                  repeats_left_next = repeats_left - REPEAT_BITS'(1);
                end
                phase_index_next = '0;
                elapsed_next     = '0;
                drive_next       = 1'b1;
              end
            end else begin
              phase_index_next = idx_inc;
              elapsed_next     = '0;
              drive_next       = ~idx_inc[0];
            end
          end else begin
            elapsed_next = elapsed_inc;
          end
        end
      end
      OP_START: begin
        if (!item.allow) begin
          blocked = 1'b1;
        end else begin
          phase_index_next  = '0;
          elapsed_next      = '0;
          repeats_left_next = item.repeats;
          active_next       = 1'b1;
          drive_next        = 1'b1;
          started           = 1'b1;
        end
      end
      OP_STOP: begin
        active_next      = 1'b0;
        drive_next       = 1'b0;
        phase_index_next = '0;
        elapsed_next     = '0;
      end
      default: begin
      end
    endcase
  end

  assign result.motor_on = drive_next;
  assign result.ringing  = active_next;
  assign result.started  = started;
  assign result.blocked  = blocked;
  assign result.finished = finished;

  // Sequencer state commits when the item moves to the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= 1'b0;
      phase_index  <= '0;
      elapsed      <= '0;
      repeats_left <= '0;
      drive        <= 1'b0;
    end else if (update) begin
      active       <= active_next;
      phase_index  <= phase_index_next;
      elapsed      <= elapsed_next;
      repeats_left <= repeats_left_next;
      drive        <= drive_next;
    end
  end

endmodule
